// File: design/sha1md_pkg.sv
// Shared constants and types for the byte-fed SHA-1 digest block.
// No dependencies; the top level and the bench import this package.
package sha1md_pkg;

   localparam int WORD_W     = 32;
   localparam int NUM_CHAIN  = 5;
   localparam int BLOCK_BYTES = 64;
   localparam int NUM_ROUNDS = 80;
   localparam int FILL_W     = $clog2(BLOCK_BYTES);
   localparam int ROUND_W    = $clog2(NUM_ROUNDS);
   localparam int LEN_W      = 64;

   typedef logic [WORD_W-1:0]                 word_type;
   typedef logic [NUM_CHAIN-1:0][WORD_W-1:0]  chain_type;

   // Standard initial chaining value, element 0 is H0
   localparam chain_type INIT_VECTOR = {
      32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
   };

   localparam word_type K_ROUND0 = 32'h5A827999;
   localparam word_type K_ROUND1 = 32'h6ED9EBA1;
   localparam word_type K_ROUND2 = 32'h8F1BBCDC;
   localparam word_type K_ROUND3 = 32'hCA62C1D6;

   localparam logic [7:0] PAD_MARK = 8'h80;

   // Sequencer states, one-hot
   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_MARK  = 7'b0000010,
      S_ZERO  = 7'b0000100,
      S_LEN   = 7'b0001000,
      S_ROUND = 7'b0010000,
      S_FOLD  = 7'b0100000,
      S_EMIT  = 7'b1000000
   } state_type;

endpackage

// File: design/sha1md_req_if.sv
// Request channel: one message byte per transaction with its flags.
// Depends on nothing.
interface sha1md_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_valid;
   logic       last_item;

   modport source (output valid, output data_byte, output byte_valid, output last_item,
                   input ready);
   modport sink   (input valid, input data_byte, input byte_valid, input last_item,
                   output ready);
endinterface

// File: design/sha1md_rsp_if.sv
// Response channel: the five 32-bit digest words of one message.
// Depends on nothing.
interface sha1md_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word0;
   logic [31:0] digest_word1;
   logic [31:0] digest_word2;
   logic [31:0] digest_word3;
   logic [31:0] digest_word4;

   modport source (output valid, output digest_word0, output digest_word1,
                   output digest_word2, output digest_word3, output digest_word4,
                   input ready);
   modport sink   (input valid, input digest_word0, input digest_word1,
                   input digest_word2, input digest_word3, input digest_word4,
                   output ready);
endinterface

// File: design/sha1_message_digest.sv
// SHA-1 digest of a byte stream: byte packing, padding sequencer and round unit.
// Depends on sha1md_pkg, sha1md_req_if and sha1md_rsp_if.

// A message enters one byte per transaction; a transaction with last_item set
// closes it (byte_valid low closes without adding a byte, which also covers the
// empty message), and one response transaction later carries the five digest
// words, H0 in digest_word0. A byte that does not complete a 64-byte block is
// stored and leaves the block open for the next byte. A byte that completes a
// block is stored, runs through the 80 rounds of the single shared round unit
// and is folded into the chaining value before the next byte is taken. Closing
// a message feeds the padding and length bytes one per cycle through the same
// path, pausing while each full block runs its rounds and fold: with p bytes in
// the open block (after the closing byte) one padded block follows when p < 56
// and two otherwise, and then the digest register is loaded. A closing byte
// that fills the block compresses it first and leaves p = 0. The digest waits
// in its own register, so the next message may start while it is still unread;
// a second digest waits until the first is taken. The bit count wraps modulo 2^64.
module sha1_message_digest
   import sha1md_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   sha1md_req_if.sink           req_ch,
   sha1md_rsp_if.source         rsp_ch
);

   localparam logic [FILL_W-1:0]  FILL_LAST  = FILL_W'(BLOCK_BYTES - 1);
   localparam logic [FILL_W-1:0]  FILL_LEN   = FILL_W'(BLOCK_BYTES - LEN_W / 8);
   localparam logic [ROUND_W-1:0] ROUND_LAST = ROUND_W'(NUM_ROUNDS - 1);
   localparam int                 WIN_W      = BLOCK_BYTES * 8;

   state_type               state_ff,   state_in;
   state_type               resume_ff,  resume_in;
   chain_type               chain_ff,   chain_in;
   chain_type               vars_ff,    vars_in;
   chain_type               digest_ff,  digest_in;
   logic [WIN_W-1:0]        window_ff,  window_in;
   logic [LEN_W-1:0]        bits_ff,    bits_in;
   logic [FILL_W-1:0]       fill_ff,    fill_in;
   logic [ROUND_W-1:0]      round_ff,   round_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   logic                    req_take;
   logic                    push_en;
   logic [7:0]              push_data;
   state_type               push_resume;

   // Round unit signals
   word_type                w_cur;
   word_type                w_next;
   word_type                f_val;
   word_type                k_val;
   word_type                t_val;

   function automatic word_type rotl(input word_type x, input int unsigned n);
      rotl = (x << n) | (x >> (WORD_W - n));
   endfunction

   assign req_take = req_ch.valid && req_ch.ready;

   // Schedule window: word 0 is the top word, the current round's W
   assign w_cur  = window_ff[WIN_W-1 -: WORD_W];
   assign w_next = rotl(window_ff[WIN_W-1-13*WORD_W -: WORD_W] ^
                        window_ff[WIN_W-1-8*WORD_W -: WORD_W] ^
                        window_ff[WIN_W-1-2*WORD_W -: WORD_W] ^ w_cur, 1);

   // Select round function and constant by round group
   always_comb begin
      if (round_ff inside {[0:19]}) begin
         f_val = (vars_ff[1] & vars_ff[2]) | (~vars_ff[1] & vars_ff[3]);
         k_val = K_ROUND0;
      end else if (round_ff inside {[20:39]}) begin
         f_val = vars_ff[1] ^ vars_ff[2] ^ vars_ff[3];
         k_val = K_ROUND1;
      end else if (round_ff inside {[40:59]}) begin
         f_val = (vars_ff[1] & vars_ff[2]) | (vars_ff[1] & vars_ff[3]) |
                 (vars_ff[2] & vars_ff[3]);
         k_val = K_ROUND2;
      end else begin
         f_val = vars_ff[1] ^ vars_ff[2] ^ vars_ff[3];
         k_val = K_ROUND3;
      end
   end

   assign t_val = rotl(vars_ff[0], 5) + f_val + vars_ff[4] + k_val + w_cur;

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      resume_in    = resume_ff;
      chain_in     = chain_ff;
      vars_in      = vars_ff;
      digest_in    = digest_ff;
      window_in    = window_ff;
      bits_in      = bits_ff;
      fill_in      = fill_ff;
      round_in     = round_ff;
      rsp_valid_in = rsp_valid_ff;
      push_en      = 1'b0;
      push_data    = '0;
      push_resume  = S_IDLE;

      // Drop the digest once the response transaction completes
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               if (req_ch.byte_valid) begin
                  push_en   = 1'b1;
                  push_data = req_ch.data_byte;
                  bits_in   = bits_ff + LEN_W'(8);
               end
               if (req_ch.last_item) begin
                  state_in    = S_MARK;
                  push_resume = S_MARK;
               end else begin
                  push_resume = S_IDLE;
               end
            end
         end
         S_MARK: begin
            push_en     = 1'b1;
            push_data   = PAD_MARK;
            state_in    = S_ZERO;
            push_resume = S_ZERO;
         end
         S_ZERO: begin
            if (fill_ff == FILL_LEN) begin
               state_in = S_LEN;
            end else begin
               push_en     = 1'b1;
               push_resume = S_ZERO;
            end
         end
         S_LEN: begin
            // Shift the length out MSB first; it ends at zero for the next message
            push_en     = 1'b1;
            push_data   = bits_ff[LEN_W-1 -: 8];
            bits_in     = {bits_ff[LEN_W-9:0], 8'h00};
            push_resume = S_EMIT;
         end
         S_ROUND: begin
            vars_in[4] = vars_ff[3];
            vars_in[3] = vars_ff[2];
            vars_in[2] = rotl(vars_ff[1], 30);
            vars_in[1] = vars_ff[0];
            vars_in[0] = t_val;
            window_in  = {window_ff[WIN_W-WORD_W-1:0], w_next};
            round_in   = round_ff + ROUND_W'(1);
            if (round_ff == ROUND_LAST) begin
               state_in = S_FOLD;
            end
         end
         S_FOLD: begin
            for (int i = 0; i < NUM_CHAIN; i++) begin
               chain_in[i] = chain_ff[i] + vars_ff[i];
            end
            state_in = resume_ff;
         end
         S_EMIT: begin
            // Hold until the digest register is free
            if (!rsp_valid_ff || rsp_ch.ready) begin
               digest_in    = chain_ff;
               rsp_valid_in = 1'b1;
               chain_in     = INIT_VECTOR;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Shift a byte into the block; a full block starts the rounds
      if (push_en) begin
         window_in = {window_ff[WIN_W-9:0], push_data};
         fill_in   = fill_ff + FILL_W'(1);
         if (fill_ff == FILL_LAST) begin
            state_in  = S_ROUND;
            resume_in = push_resume;
            vars_in   = chain_ff;
            round_in  = '0;
         end
      end
   end

   // Control and chaining state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         resume_ff    <= S_IDLE;
         chain_ff     <= INIT_VECTOR;
         vars_ff      <= '0;
         bits_ff      <= '0;
         fill_ff      <= '0;
         round_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         resume_ff    <= resume_in;
         chain_ff     <= chain_in;
         vars_ff      <= vars_in;
         bits_ff      <= bits_in;
         fill_ff      <= fill_in;
         round_ff     <= round_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Block window and digest payload
   always_ff @(posedge clock) begin
      window_ff <= window_in;
      digest_ff <= digest_in;
   end

   assign req_ch.ready        = (state_ff == S_IDLE);
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.digest_word0 = digest_ff[0];
   assign rsp_ch.digest_word1 = digest_ff[1];
   assign rsp_ch.digest_word2 = digest_ff[2];
   assign rsp_ch.digest_word3 = digest_ff[3];
   assign rsp_ch.digest_word4 = digest_ff[4];

`ifndef SYNTHESIS
   // Round counter stays inside the round range
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROUND) |-> (round_ff <= ROUND_LAST))
      else $error("round counter out of range");

   // Rounds only run on a freshly completed block
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROUND) |-> (fill_ff == '0))
      else $error("rounds running on a partial block");

   // Length bytes go only into the last eight slots
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LEN) |-> (fill_ff >= FILL_LEN))
      else $error("length field misplaced");

   // A closed message leaves the length and fill position cleared
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT) |-> (bits_ff == '0 && fill_ff == '0))
      else $error("message state not cleared at digest");

   // The digest register is loaded only when it is free
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ch.ready) |=> $stable(digest_ff))
      else $error("pending digest overwritten");
`endif

endmodule

// File: verif/tb.sv
// Self-checking bench for the byte-fed SHA-1 digest block: directed, random, back-pressure.
// Depends on sha1md_pkg, sha1md_req_if, sha1md_rsp_if and sha1_message_digest.
module tb
   import sha1md_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITEM_TARGET = 1300;
   localparam int CYCLE_LIMIT = 3_000_000;
   localparam int HOLD_CYCLES = 2500;

   logic clock = 1'b0;
   logic reset;

   sha1md_req_if req_if ();
   sha1md_rsp_if rsp_if ();

   sha1_message_digest i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if.sink),
      .rsp_ch (rsp_if.source)
   );

   // Generate the 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mirror of the hashing state
   word_type   sha_block [16];
   chain_type  sha_chain;
   logic [63:0] sha_bit_count;
   logic [5:0]  sha_fill;

   chain_type expected_digests [$];

   int error_count   = 0;
   int digests_seen  = 0;
   int bytes_sent    = 0;
   int closes_sent   = 0;
   int idles_sent    = 0;
   int cycle_count   = 0;
   bit send_quiet    = 1'b0;
   bit rsp_quiet     = 1'b0;
   int hold_off_cycles = 0;
   bit hold_active   = 1'b0;

   function automatic word_type rotl(word_type x, int n);
      return (x << n) | (x >> (32 - n));
   endfunction

   // Run the 80 rounds over the current block and fold into the chain
   function automatic void sha_compress();
      word_type a, b, c, d, e, w, f, k, t;
      a = sha_chain[0];
      b = sha_chain[1];
      c = sha_chain[2];
      d = sha_chain[3];
      e = sha_chain[4];
      for (int r = 0; r < NUM_ROUNDS; r++) begin
         if (r < 16) begin
            w = sha_block[r];
         end else begin
            w = rotl(sha_block[(r + 13) & 15] ^ sha_block[(r + 8) & 15] ^
                     sha_block[(r + 2) & 15] ^ sha_block[r & 15], 1);
            sha_block[r & 15] = w;
         end
         if (r < 20) begin
            f = (b & c) | (~b & d);
            k = K_ROUND0;
         end else if (r < 40) begin
            f = b ^ c ^ d;
            k = K_ROUND1;
         end else if (r < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = K_ROUND2;
         end else begin
            f = b ^ c ^ d;
            k = K_ROUND3;
         end
         t = rotl(a, 5) + f + e + k + w;
         e = d;
         d = c;
         c = rotl(b, 30);
         b = a;
         a = t;
      end
      sha_chain[0] += a;
      sha_chain[1] += b;
      sha_chain[2] += c;
      sha_chain[3] += d;
      sha_chain[4] += e;
   endfunction

   // Place one byte big-endian; compress when the block fills
   function automatic void sha_put_byte(logic [7:0] value);
      int idx, sh;
      idx = sha_fill[5:2];
      sh  = 24 - 8 * sha_fill[1:0];
      sha_block[idx] = (sha_block[idx] & ~(32'hFF << sh)) | (word_type'(value) << sh);
      sha_fill = sha_fill + 6'd1;
      if (sha_fill == 6'd0) sha_compress();
   endfunction

   // Absorb one accepted transaction; on a close, pad and queue the digest
   function automatic void sha_absorb(logic [7:0] value, logic byte_ok, logic close);
      logic [63:0] len;
      if (byte_ok) begin
         sha_put_byte(value);
         sha_bit_count += 64'd8;
      end
      if (!close) return;
      len = sha_bit_count;
      sha_put_byte(PAD_MARK);
      if (sha_fill > 6'd56) begin
         while (sha_fill != 6'd0) sha_put_byte(8'h00);
      end
      while (sha_fill != 6'd56) sha_put_byte(8'h00);
      for (int i = 0; i < 8; i++) sha_put_byte(len[63 - 8 * i -: 8]);
      expected_digests.insert(expected_digests.size(), sha_chain);
      sha_chain     = INIT_VECTOR;
      sha_bit_count = '0;
      sha_fill      = '0;
   endfunction

   // Mostly short gaps, a few long ones
   function automatic int pick_gap(bit quiet);
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   task automatic report_mismatch(string what, word_type got, word_type want);
      $display("mismatch %s: got %08h, want %08h (digest %0d)", what, got, want, digests_seen);
      error_count++;
   endtask

   // Offer one transaction, hold it until accepted, then predict
   task automatic send_item(logic [7:0] value, logic byte_ok, logic close);
      int gap;
      gap = pick_gap(send_quiet);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.data_byte  <= value;
      req_if.byte_valid <= byte_ok;
      req_if.last_item  <= close;
      do @(posedge clock); while (!req_if.ready);
      sha_absorb(value, byte_ok, close);
      if (byte_ok) bytes_sent++;
      if (close) closes_sent++;
      if (!byte_ok && !close) idles_sent++;
   endtask

   // Empty message, short strings, byte extremes and idle transactions
   task automatic test_directed();
      send_item(8'($urandom), 1'b0, 1'b1);
      send_item(8'h61, 1'b1, 1'b0);
      send_item(8'h62, 1'b1, 1'b0);
      send_item(8'h63, 1'b1, 1'b1);
      send_item(8'($urandom), 1'b0, 1'b0);
      send_item(8'h61, 1'b1, 1'b0);
      send_item(8'h62, 1'b1, 1'b0);
      send_item(8'($urandom), 1'b0, 1'b0);
      send_item(8'($urandom), 1'b0, 1'b1);
      send_item(8'h00, 1'b1, 1'b1);
      send_item(8'hFF, 1'b1, 1'b1);
      send_item(8'hFF, 1'b1, 1'b0);
      send_item(8'h00, 1'b1, 1'b0);
      send_item(8'($urandom), 1'b0, 1'b1);
   endtask

   // Random messages, lengths weighted toward short ones and block edges
   task automatic test_random_messages();
      int edges [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
      int len, r, pattern;
      bit split_close;
      logic [7:0] value;
      while (bytes_sent + closes_sent + idles_sent < ITEM_TARGET) begin
         r = $urandom_range(0, 99);
         if (r < 50) len = $urandom_range(0, 8);
         else if (r < 75) len = $urandom_range(9, 70);
         else if (r < 92) len = edges[$urandom_range(0, 9)];
         else if (r < 98) len = $urandom_range(129, 200);
         else len = $urandom_range(256, 400);
         pattern     = $urandom_range(0, 9);
         split_close = (len == 0) || ($urandom_range(0, 9) < 3);
         send_quiet  = ($urandom_range(0, 6) == 0);
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) == 0) send_item(8'($urandom), 1'b0, 1'b0);
            if (pattern == 0) value = 8'h00;
            else if (pattern == 1) value = 8'hFF;
            else value = 8'($urandom);
            send_item(value, 1'b1, (i == len - 1) && !split_close);
         end
         if (split_close) send_item(8'($urandom), 1'b0, 1'b1);
      end
      send_quiet = 1'b0;
   endtask

   // Hold the digest side off while short messages keep coming
   task automatic test_back_pressure();
      int len;
      req_if.valid    <= 1'b0;
      hold_off_cycles = HOLD_CYCLES;
      wait (hold_active);
      send_quiet = 1'b1;
      for (int m = 0; m < 6; m++) begin
         len = $urandom_range(1, 5);
         for (int i = 0; i < len; i++) send_item(8'($urandom), 1'b1, i == len - 1);
      end
      send_quiet = 1'b0;
   endtask

   // Drive digest-side ready: random gaps, quiet stretches, one long hold-off
   initial begin
      int gap;
      int hold_count;
      bit ready_drv;
      rsp_if.ready <= 1'b0;
      ready_drv = 1'b0;
      repeat (5) @(posedge clock);
      forever begin
         if (hold_off_cycles > 0) begin
            hold_active = 1'b1;
            if (ready_drv) rsp_if.ready <= 1'b0;
            ready_drv  = 1'b0;
            hold_count = 0;
            while (hold_count < hold_off_cycles) begin
               @(posedge clock);
               hold_count++;
            end
            hold_off_cycles = 0;
            hold_active     = 1'b0;
         end else begin
            rsp_quiet = ($urandom_range(0, 9) == 0);
            gap = pick_gap(rsp_quiet);
            if (gap > 0) begin
               if (ready_drv) rsp_if.ready <= 1'b0;
               ready_drv = 1'b0;
               repeat (gap) @(posedge clock);
            end
            if (!ready_drv) rsp_if.ready <= 1'b1;
            ready_drv = 1'b1;
            repeat (rsp_quiet ? 200 : $urandom_range(1, 24)) @(posedge clock);
         end
      end
   end

   // Check each digest transaction against the oldest prediction
   always @(posedge clock) begin
      chain_type got, want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = {rsp_if.digest_word4, rsp_if.digest_word3, rsp_if.digest_word2,
                rsp_if.digest_word1, rsp_if.digest_word0};
         if (expected_digests.size() == 0) begin
            $display("unexpected digest %h", got);
            error_count++;
         end else begin
            want = expected_digests.pop_front();
            for (int i = 0; i < NUM_CHAIN; i++) begin
               if (got[i] !== want[i])
                  report_mismatch($sformatf("digest_word%0d", i), got[i], want[i]);
            end
         end
         digests_seen++;
      end
   end

   // Stop a hung run
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d digests outstanding",
               cycle_count, expected_digests.size());
      $display("status: fail");
      $finish;
   end

   // Reset, run the tests in turn, drain and report
   initial begin
      for (int i = 0; i < 16; i++) sha_block[i] = '0;
      sha_chain     = INIT_VECTOR;
      sha_bit_count = '0;
      sha_fill      = '0;
      reset             <= 1'b1;
      req_if.valid      <= 1'b0;
      req_if.data_byte  <= 8'h00;
      req_if.byte_valid <= 1'b0;
      req_if.last_item  <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random_messages();
      test_back_pressure();

      req_if.valid <= 1'b0;
      wait (expected_digests.size() == 0);
      repeat (400) @(posedge clock);

      $display("ran %0d message bytes, %0d closes and %0d idle transactions;",
               bytes_sent, closes_sent, idles_sent);
      $display("checked %0d digests, including one long digest-side hold-off", digests_seen);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d mismatches", error_count);
         $display("status: fail");
      end
      $finish;
   end

endmodule
